/* src/spq_pkg.sv */
`default_nettype none

package spq_pkg;

  localparam int unsigned SPQ_DEPTH = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SHOW   = 1'b1;

  localparam logic [1:0] ST_DUMP   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;
  localparam logic [1:0] ST_DROP   = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [7:0]         character;
    logic signed [15:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [7:0]         character_res;
    logic signed [15:0] priority_res;
    logic [1:0]         status;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [7:0]         character;
    logic signed [15:0] pri;
  } entry_t;

endpackage

`default_nettype wire

/* src/spq_mem.sv */
`default_nettype none

module spq_mem #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire spq_pkg::entry_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output spq_pkg::entry_t      rdata_o
);
  import spq_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/spq_outreg.sv */
`default_nettype none

module spq_outreg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire spq_pkg::res_t data_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spq_pkg::res_t      out_res_o
);
  import spq_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  // The register can take a new result when empty or when its current one leaves now.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = data_q;

endmodule

`default_nettype wire

/* src/sorted_priority_queue.sv */
`default_nettype none

// Sorted priority queue of up to DEPTH entries (character plus signed 16-bit
// priority), held in one single-port-read, single-port-write memory in
// ascending priority order; entries of equal priority keep arrival order.
// An insert request scans from the back of the store, moving each entry of
// higher priority up by one slot, one memory read and one write per cycle,
// so an insert into a non-empty store with room passes through the scan state,
// and the place state when the new entry goes to the front, before its
// acknowledge is ready. An insert into an empty or a full store, and a show
// on an empty store, go straight to the response state. A show request dumps
// the entries front to back, reading the registered memory only while the
// single result register is free. One request is worked on at a time; a new
// request is taken as soon as the last result of the previous one sits in
// the output register. No clearing pass is needed after reset.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire spq_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spq_pkg::res_t      out_res_o
);
  import spq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_RESP  = 3'd3;
  localparam logic [2:0] S_DUMP  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic [1:0]    status_q, status_d;
  entry_t        new_q, new_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  logic          out_load, out_free;
  res_t          out_data;
  entry_t        in_entry;

  assign in_entry.character = in_req_i.character;
  assign in_entry.pri       = in_req_i.priority_req;
  assign in_ready_o         = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    rd_pend_d = rd_pend_q;
    status_d  = status_q;
    new_d     = new_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    out_data  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          new_d = in_entry;
          if (in_req_i.operation == OP_INSERT) begin
            if (cnt_q == CW'(DEPTH)) begin
              status_d = ST_DROP;
              state_d  = S_RESP;
            end else if (cnt_q == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = in_entry;
              cnt_d     = cnt_q + CW'(1);
              status_d  = ST_ACCEPT;
              state_d   = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(cnt_q - CW'(1));
              pos_d     = AW'(cnt_q - CW'(1));
              state_d   = S_SCAN;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              idx_d     = '0;
              rd_pend_d = 1'b0;
              state_d   = S_DUMP;
            end
          end
        end
      end
      S_SCAN: begin
        // Read data belongs to slot pos_q; reads run one slot ahead of writes.
        mem_we    = 1'b1;
        mem_waddr = pos_q + AW'(1);
        if ($signed(mem_rdata.pri) > $signed(new_q.pri)) begin
          mem_wdata = mem_rdata;
          if (pos_q == '0) begin
            state_d = S_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_q - AW'(1);
            pos_d     = pos_q - AW'(1);
          end
        end else begin
          mem_wdata = new_q;
          cnt_d     = cnt_q + CW'(1);
          status_d  = ST_ACCEPT;
          state_d   = S_RESP;
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = new_q;
        cnt_d     = cnt_q + CW'(1);
        status_d  = ST_ACCEPT;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_data.status = status_q;
          out_data.last   = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DUMP: begin
        if (rd_pend_q) begin
          // The read was issued only while the output register was free.
          out_load               = 1'b1;
          out_data.character_res = mem_rdata.character;
          out_data.priority_res  = mem_rdata.pri;
          out_data.status        = ST_DUMP;
          out_data.last          = ((CW'(idx_q) + CW'(1)) == cnt_q);
          rd_pend_d              = 1'b0;
          if ((CW'(idx_q) + CW'(1)) == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end else if (out_free) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q;
          rd_pend_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    new_q    <= new_d;
  end

  spq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  spq_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .data_i      (out_data),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("entry count changed by other than one");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten while holding a result");

  a_pend_in_dump : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_DUMP))
    else $error("dump read pending outside the dump state");

  a_write_not_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory written and read at the same slot");

endmodule

`default_nettype wire
